// ===== design/pmsd_pkg.sv =====
// shared types and constants for the per-dimension mean and deviation block
package pmsd_pkg;

   localparam int DIM_SLOTS  = 8;   // dimension slots carried by one word
   localparam int DIV_W      = 96;  // dividend width of the shared divider
   localparam int DIV_CNT_W  = 7;   // bit counter of the divider
   localparam int ELEM_W     = 32;
   localparam int DIMS_CFG_W = 4;
   localparam int DIM_IDX_W  = 3;

   typedef struct packed {
      logic signed [31:0] element_0;
      logic signed [31:0] element_1;
      logic signed [31:0] element_2;
      logic signed [31:0] element_3;
      logic signed [31:0] element_4;
      logic signed [31:0] element_5;
      logic signed [31:0] element_6;
      logic signed [31:0] element_7;
      logic               final_sample;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         dim_index;
      logic signed [31:0] mean_value;
      logic [31:0]        std_dev;
      logic [31:0]        largest_std_dev;
      logic               overflowed;
      logic               last_result;
   } rsp_word_type;

endpackage

// ===== design/pmsd_req_if.sv =====
// sample channel
interface pmsd_req_if;
   logic                  valid;
   logic                  ready;
   pmsd_pkg::req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/pmsd_rsp_if.sv =====
// result channel
interface pmsd_rsp_if;
   logic                  valid;
   logic                  ready;
   pmsd_pkg::rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/pmsd_div.sv =====
// restoring divider, one quotient bit per cycle
module pmsd_div #(
   parameter int DVS_W = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pmsd_pkg::DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0]           divisor,
   output logic                       busy,
   output logic [pmsd_pkg::DIV_W-1:0] quotient
);

   logic [DVS_W-1:0]               rem_ff, rem_in;
   logic [pmsd_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [pmsd_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic [DVS_W:0]                 shifted;
   logic [DVS_W:0]                 diff;
   logic                           qbit;

   always_comb begin
      shifted = {rem_ff, quo_ff[pmsd_pkg::DIV_W-1]};
      diff    = shifted - {1'b0, divisor};
      qbit    = (shifted >= {1'b0, divisor});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = pmsd_pkg::DIV_CNT_W'(pmsd_pkg::DIV_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = qbit ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_in  = {quo_ff[pmsd_pkg::DIV_W-2:0], qbit};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/pmsd_sqrt.sv =====
// bit-pair integer square root of a 64-bit value
module pmsd_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        busy,
   output logic [31:0] root
);

   logic [63:0] op_ff, op_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] one_ff, one_in;
   logic        busy_ff, busy_in;
   logic [63:0] trial;

   always_comb begin
      trial   = res_ff + one_ff;
      op_in   = op_ff;
      res_in  = res_ff;
      one_in  = one_ff;
      busy_in = busy_ff;
      if (start) begin
         op_in   = value;
         res_in  = '0;
         one_in  = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (op_ff >= trial) begin
            op_in  = op_ff - trial;
            res_in = (res_ff >> 1) + one_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         one_in  = one_ff >> 2;
         busy_in = !one_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      op_ff  <= op_in;
      res_ff <= res_in;
      one_ff <= one_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[31:0];

endmodule

// ===== design/per_dimension_mean_std.sv =====
// Collects samples of up to MAX_DIMS signed Q16.16 elements, one word per cycle while
// ready is high, into one memory bank per dimension. The word with final_sample set
// closes the set and the block drops ready while it works out each dimension in use:
// a sum pass that reads and accumulates each sample, a division for the mean, a square
// pass that reads, takes the magnitude, squares and accumulates each sample, a division
// of the squared sum and a square root, all on one shared divider and one root unit.
// One result word per dimension follows, then the block takes samples again.
// Words beyond MAX_SAMPLES are dropped and flagged in overflowed.
module per_dimension_mean_std #(
   parameter int MAX_SAMPLES = 256,
   parameter int MAX_DIMS    = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   pmsd_req_if.sink                            req_if,
   pmsd_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic [pmsd_pkg::DIMS_CFG_W-1:0]     csr_wdata
);

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int SW = 32 + CW;
   localparam int QW = 64 + CW;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SUM_RD    = 4'd1;
   localparam logic [3:0] S_SUM_ACC   = 4'd2;
   localparam logic [3:0] S_MDIV_GO   = 4'd3;
   localparam logic [3:0] S_MDIV_WAIT = 4'd4;
   localparam logic [3:0] S_SQ_RD     = 4'd5;
   localparam logic [3:0] S_SQ_MAG    = 4'd6;
   localparam logic [3:0] S_SQ_MUL    = 4'd7;
   localparam logic [3:0] S_SQ_ACC    = 4'd8;
   localparam logic [3:0] S_VDIV_GO   = 4'd9;
   localparam logic [3:0] S_VDIV_WAIT = 4'd10;
   localparam logic [3:0] S_SQRT_GO   = 4'd11;
   localparam logic [3:0] S_SQRT_WAIT = 4'd12;
   localparam logic [3:0] S_NEXT      = 4'd13;
   localparam logic [3:0] S_OUT       = 4'd14;

   logic [3:0]                          state_ff, state_in;
   logic [CW-1:0]                       cnt_ff, cnt_in;
   logic                                drop_ff, drop_in;
   logic [pmsd_pkg::DIMS_CFG_W-1:0]     dims_ff;
   logic [pmsd_pkg::DIM_IDX_W-1:0]      last_d_ff, last_d_in;
   logic [pmsd_pkg::DIM_IDX_W-1:0]      d_ff, d_in;
   logic [CW-1:0]                       idx_ff, idx_in;
   logic signed [SW-1:0]                sum_ff, sum_in;
   logic [QW-1:0]                       sq_ff, sq_in;
   logic [31:0]                         mag_ff, mag_in;
   logic [63:0]                         prod_ff, prod_in;
   logic                                neg_ff, neg_in;
   logic [31:0]                         mean_ff [pmsd_pkg::DIM_SLOTS];
   logic [31:0]                         std_ff [pmsd_pkg::DIM_SLOTS];
   logic [31:0]                         largest_ff;
   logic [31:0]                         rd_data_ff [pmsd_pkg::DIM_SLOTS];
   logic [31:0]                         elem_all [pmsd_pkg::DIM_SLOTS];

   logic                                accept;
   logic                                wr_en;
   logic                                rd_en;
   logic [31:0]                         x;
   logic [SW-1:0]                       sum_abs;
   logic [32:0]                         diff;
   logic [31:0]                         mean_res;
   logic [63:0]                         var_sat;
   logic                                div_start, div_busy, sqrt_start, sqrt_busy;
   logic [pmsd_pkg::DIV_W-1:0]          div_dividend, div_quo;
   logic [31:0]                         root;
   logic                                last_idx;

   assign accept = req_if.valid && req_if.ready;
   assign wr_en  = accept && (cnt_ff < CW'(MAX_SAMPLES));
   assign rd_en  = (state_ff == S_SUM_RD) || (state_ff == S_SQ_RD);

   assign elem_all[0] = req_if.payload.element_0;
   assign elem_all[1] = req_if.payload.element_1;
   assign elem_all[2] = req_if.payload.element_2;
   assign elem_all[3] = req_if.payload.element_3;
   assign elem_all[4] = req_if.payload.element_4;
   assign elem_all[5] = req_if.payload.element_5;
   assign elem_all[6] = req_if.payload.element_6;
   assign elem_all[7] = req_if.payload.element_7;

   // one bank per dimension, all written with one word, all read at one address
   for (genvar g = 0; g < pmsd_pkg::DIM_SLOTS; g++) begin : g_bank
      if (g < MAX_DIMS) begin : g_used
         logic [31:0] mem [MAX_SAMPLES];
         always_ff @(posedge clock) begin
            if (wr_en) begin
               mem[cnt_ff[AW-1:0]] <= elem_all[g];
            end
            if (rd_en) begin
               rd_data_ff[g] <= mem[idx_ff[AW-1:0]];
            end
         end
      end else begin : g_unused
         assign rd_data_ff[g] = '0;
      end
   end

   pmsd_div #(.DVS_W(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cnt_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   pmsd_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (var_sat),
      .busy  (sqrt_busy),
      .root  (root)
   );

   always_comb begin
      x            = rd_data_ff[d_ff];
      sum_abs      = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
      diff         = {x[31], x} - {mean_ff[d_ff][31], mean_ff[d_ff]};
      mean_res     = neg_ff ? (32'd0 - div_quo[31:0]) : div_quo[31:0];
      var_sat      = (|div_quo[pmsd_pkg::DIV_W-1:64]) ? '1 : div_quo[63:0];
      div_start    = (state_ff == S_MDIV_GO) || (state_ff == S_VDIV_GO);
      div_dividend = (state_ff == S_MDIV_GO) ? pmsd_pkg::DIV_W'(sum_abs)
                                             : pmsd_pkg::DIV_W'(sq_ff);
      sqrt_start   = (state_ff == S_SQRT_GO);
      last_idx     = (idx_ff == cnt_ff - 1'b1);
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      drop_in   = drop_ff;
      last_d_in = last_d_ff;
      d_in      = d_ff;
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      sq_in     = sq_ff;
      mag_in    = mag_ff;
      prod_in   = prod_ff;
      neg_in    = neg_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (wr_en) begin
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_if.payload.final_sample) begin
                  // zero acts as one dimension, too many as all of them
                  if (dims_ff == '0) begin
                     last_d_in = '0;
                  end else if (dims_ff > pmsd_pkg::DIMS_CFG_W'(MAX_DIMS)) begin
                     last_d_in = pmsd_pkg::DIM_IDX_W'(MAX_DIMS - 1);
                  end else begin
                     last_d_in = pmsd_pkg::DIM_IDX_W'(dims_ff - 1'b1);
                  end
                  d_in     = '0;
                  idx_in   = '0;
                  sum_in   = '0;
                  state_in = S_SUM_RD;
               end
            end
         end
         S_SUM_RD: begin
            state_in = S_SUM_ACC;
         end
         S_SUM_ACC: begin
            sum_in = sum_ff + SW'(signed'(x));
            idx_in = idx_ff + 1'b1;
            state_in = last_idx ? S_MDIV_GO : S_SUM_RD;
         end
         S_MDIV_GO: begin
            neg_in   = sum_ff[SW-1];
            state_in = S_MDIV_WAIT;
         end
         S_MDIV_WAIT: begin
            if (!div_busy) begin
               idx_in   = '0;
               sq_in    = '0;
               state_in = S_SQ_RD;
            end
         end
         S_SQ_RD: begin
            state_in = S_SQ_MAG;
         end
         S_SQ_MAG: begin
            mag_in   = diff[32] ? 32'(-diff) : diff[31:0];
            state_in = S_SQ_MUL;
         end
         S_SQ_MUL: begin
            prod_in  = mag_ff * mag_ff;
            state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            sq_in    = sq_ff + QW'(prod_ff);
            idx_in   = idx_ff + 1'b1;
            state_in = last_idx ? S_VDIV_GO : S_SQ_RD;
         end
         S_VDIV_GO: begin
            state_in = S_VDIV_WAIT;
         end
         S_VDIV_WAIT: begin
            if (!div_busy) begin
               state_in = S_SQRT_GO;
            end
         end
         S_SQRT_GO: begin
            state_in = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (!sqrt_busy) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (d_ff == last_d_ff) begin
               d_in     = '0;
               state_in = S_OUT;
            end else begin
               d_in     = d_ff + 1'b1;
               idx_in   = '0;
               sum_in   = '0;
               state_in = S_SUM_RD;
            end
         end
         S_OUT: begin
            if (rsp_if.ready) begin
               if (d_ff == last_d_ff) begin
                  cnt_in   = '0;
                  drop_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  d_in = d_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
         dims_ff  <= pmsd_pkg::DIMS_CFG_W'(8);
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         drop_ff  <= drop_in;
         if (csr_we) begin
            dims_ff <= csr_wdata;
         end
      end
      last_d_ff <= last_d_in;
      d_ff      <= d_in;
      idx_ff    <= idx_in;
      sum_ff    <= sum_in;
      sq_ff     <= sq_in;
      mag_ff    <= mag_in;
      prod_ff   <= prod_in;
      neg_ff    <= neg_in;
      if (state_ff == S_MDIV_WAIT && !div_busy) begin
         mean_ff[d_ff] <= mean_res;
      end
      if (state_ff == S_SQRT_WAIT && !sqrt_busy) begin
         std_ff[d_ff] <= root;
         if (d_ff == '0 || root > largest_ff) begin
            largest_ff <= root;
         end
      end
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_if.valid = (state_ff == S_OUT);

   always_comb begin
      rsp_if.payload.dim_index       = d_ff;
      rsp_if.payload.mean_value      = mean_ff[d_ff];
      rsp_if.payload.std_dev         = std_ff[d_ff];
      rsp_if.payload.largest_std_dev = largest_ff;
      rsp_if.payload.overflowed      = drop_ff;
      rsp_if.payload.last_result     = (d_ff == last_d_ff);
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("sample port open while results are pending");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_SAMPLES))
      else $error("sample count past capacity");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && rsp_if.payload.last_result
      |=> cnt_ff == '0 && !drop_ff)
      else $error("set not cleared after its last word");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(div_busy && sqrt_busy))
      else $error("divider and root unit busy together");

endmodule

// ===== test/pmsd_test_if.sv =====
// testbench helpers: wide arithmetic type and integer square root
package pmsd_test_pkg;

   // saturated variance work is done in 128 bits
   typedef logic [127:0] wide_type;

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] op;
      logic [63:0] res;
      logic [63:0] one;
      op = v;
      res = 0;
      one = 64'h4000_0000_0000_0000;
      while (one > op) one = one >> 2;
      while (one != 0) begin
         if (op >= res + one) begin
            op = op - (res + one);
            res = (res >> 1) + one;
         end else begin
            res = res >> 1;
         end
         one = one >> 2;
      end
      return res;
   endfunction
endpackage

// ===== test/per_dimension_mean_std_test.sv =====
// self-checking testbench for the per-dimension mean and deviation block
module per_dimension_mean_std_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 256;
   localparam int WATCHDOG_LIMIT = 100000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [pmsd_pkg::DIMS_CFG_W-1:0] csr_wdata;

   pmsd_req_if req_if ();
   pmsd_rsp_if rsp_if ();

   per_dimension_mean_std dut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic signed [31:0] stored_samples [CAPACITY][pmsd_pkg::DIM_SLOTS];
   int stored_count;
   bit dropped_any;
   logic [pmsd_pkg::DIMS_CFG_W-1:0] dims_reg;

   pmsd_pkg::req_word_type pending_words [$];
   int pending_last_pause [$];
   pmsd_pkg::rsp_word_type expected_results [$];

   int errors;
   int words_sent;
   int results_seen;
   int sets_closed;
   int idle_cycles;
   bit hold_off_request;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // apply one accepted word to the predictor
   task automatic predict_word(input pmsd_pkg::req_word_type w);
      logic signed [31:0] elems [pmsd_pkg::DIM_SLOTS];
      logic signed [63:0] means [pmsd_pkg::DIM_SLOTS];
      logic [31:0] devs [pmsd_pkg::DIM_SLOTS];
      logic [31:0] largest;
      logic signed [63:0] total;
      logic signed [63:0] diff;
      logic [63:0] mag;
      pmsd_test_pkg::wide_type sq_sum;
      pmsd_test_pkg::wide_type quot;
      logic [63:0] root;
      int active;
      pmsd_pkg::rsp_word_type r;
      elems = '{w.element_0, w.element_1, w.element_2, w.element_3,
                w.element_4, w.element_5, w.element_6, w.element_7};
      if (stored_count < CAPACITY) begin
         for (int d = 0; d < pmsd_pkg::DIM_SLOTS; d++)
            stored_samples[stored_count][d] = elems[d];
         stored_count++;
      end else begin
         dropped_any = 1;
      end
      if (!w.final_sample) return;
      active = (dims_reg == 0) ? 1 :
               (dims_reg > pmsd_pkg::DIM_SLOTS ? pmsd_pkg::DIM_SLOTS : int'(dims_reg));
      largest = 0;
      for (int d = 0; d < active; d++) begin
         total = 0;
         for (int i = 0; i < stored_count; i++) total += stored_samples[i][d];
         means[d] = (stored_count != 0) ? total / stored_count : 0;
         sq_sum = 0;
         for (int i = 0; i < stored_count; i++) begin
            diff = stored_samples[i][d] - means[d];
            mag = (diff < 0) ? -diff : diff;
            sq_sum += pmsd_test_pkg::wide_type'(mag) * pmsd_test_pkg::wide_type'(mag);
         end
         if (stored_count != 0) begin
            quot = sq_sum / stored_count;
            root = pmsd_test_pkg::root_floor((quot[127:64] != 0) ? '1 : quot[63:0]);
            devs[d] = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
         end else begin
            devs[d] = 0;
         end
         if (d == 0 || devs[d] > largest) largest = devs[d];
      end
      for (int d = 0; d < active; d++) begin
         r.dim_index = d[2:0];
         r.mean_value = means[d][31:0];
         r.std_dev = devs[d];
         r.largest_std_dev = largest;
         r.overflowed = dropped_any;
         r.last_result = (d + 1 == active);
         expected_results.push_back(r);
      end
      stored_count = 0;
      dropped_any = 0;
      sets_closed++;
   endtask

   function automatic logic signed [31:0] pick_element(int style);
      case (style)
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         3: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_sample(input int style, input bit closing, input int pause_after);
      pmsd_pkg::req_word_type w;
      w.element_0 = pick_element(style); w.element_1 = pick_element(style);
      w.element_2 = pick_element(style); w.element_3 = pick_element(style);
      w.element_4 = pick_element(style); w.element_5 = pick_element(style);
      w.element_6 = pick_element(style); w.element_7 = pick_element(style);
      w.final_sample = closing;
      pending_words.push_back(w);
      pending_last_pause.push_back(pause_after);
   endtask

   // driver
   int send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 0;
         req_if.payload <= '0;
         send_gap <= 0;
      end else if (req_if.valid && req_if.ready) begin
         if (pending_words.size() > 0 && $urandom_range(0, 3) == 0) begin
            req_if.payload <= pending_words.pop_front();
            void'(pending_last_pause.pop_front());
         end else begin
            req_if.valid <= 0;
            send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
         end
      end else if (!req_if.valid) begin
         if (send_gap > 0) send_gap <= send_gap - 1;
         else if (pending_words.size() > 0 && pending_last_pause[0] == 0) begin
            req_if.valid <= 1;
            req_if.payload <= pending_words.pop_front();
            void'(pending_last_pause.pop_front());
         end
      end
   end

   // predictor follows accepted words
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         predict_word(req_if.payload);
         words_sent++;
      end
   end

   // monitor and receiver
   int recv_gap;
   int hold_count;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 0;
         recv_gap <= 0;
         hold_count <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result word %p", $realtime, rsp_if.payload);
            end else begin
               pmsd_pkg::rsp_word_type e;
               e = expected_results.pop_front();
               if (e !== rsp_if.payload) begin
                  errors++;
                  $display("%0t: mismatch expected %p actual %p", $realtime, e,
                           rsp_if.payload);
               end
            end
         end
         if (hold_off_request && hold_count == 0) begin
            hold_count <= 3000;
            rsp_if.ready <= 0;
         end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            rsp_if.ready <= 0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_if.ready <= 0;
         end else if (rsp_if.ready && rsp_if.valid) begin
            recv_gap <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
            rsp_if.ready <= 0;
         end else begin
            rsp_if.ready <= 1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("per_dimension_mean_std test failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_if.valid || expected_results.size() > 0)
         @(posedge clock);
      // a final word may still be in the pipe with a set in progress
      repeat (20) @(posedge clock);
   endtask

   task automatic write_dims(input int value);
      @(posedge clock);
      csr_we <= 1;
      csr_wdata <= pmsd_pkg::DIMS_CFG_W'(value);
      @(posedge clock);
      csr_we <= 0;
      dims_reg = pmsd_pkg::DIMS_CFG_W'(value);
   endtask

   // one set of n samples with the given element style
   task automatic queue_set(input int n, input int style);
      for (int i = 0; i < n; i++) queue_sample(style, i == n - 1, 0);
   endtask

   initial begin
      int sent_target;
      hold_off_request = 0;
      dims_reg = 8;
      reset <= 1; csr_we <= 0; csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: extremes, a single-sample set, mixed extremes
      queue_set(1, 0);
      queue_set(2, 1);
      queue_set(3, 2);
      queue_set(4, 3);
      queue_set(2, 4);
      queue_set(6, 2);
      wait_drained();
      write_dims(1);
      queue_set(3, 4);
      queue_set(2, 2);
      wait_drained();
      write_dims(0);
      queue_set(2, 3);
      wait_drained();
      write_dims(15);
      queue_set(2, 2);
      wait_drained();

      // overflow: fill the store past capacity, final word dropped
      write_dims(3);
      queue_set(CAPACITY + 4, 4);
      wait_drained();

      // long receiver stall while three sets queue up behind it
      write_dims(8);
      hold_off_request = 1;
      queue_set(3, 4);
      queue_set(4, 3);
      queue_set(2, 4);
      wait (hold_count > 0);
      hold_off_request = 0;
      wait_drained();

      // random sets, mostly small
      sent_target = words_sent + 60;
      while (words_sent < sent_target) begin
         if ($urandom_range(0, 9) == 0) begin
            wait_drained();
            write_dims($urandom_range(0, 15));
         end
         queue_set($urandom_range(1, 12), $urandom_range(0, 5) < 2 ? $urandom_range(0, 3) : 4);
         while (pending_words.size() > 4) @(posedge clock);
      end
      wait_drained();
      repeat (50) @(posedge clock);

      $display("covered %0d sample words, %0d sets closed, %0d result words checked",
               words_sent, sets_closed, results_seen);
      if (errors == 0 && expected_results.size() == 0)
         $display("per_dimension_mean_std test passed");
      else
         $display("per_dimension_mean_std test failed");
      $finish;
   end
endmodule

// ===== per_dimension_mean_std.f =====
design/pmsd_pkg.sv
design/pmsd_req_if.sv
design/pmsd_rsp_if.sv
design/pmsd_div.sv
design/pmsd_sqrt.sv
design/per_dimension_mean_std.sv
test/pmsd_test_if.sv
test/per_dimension_mean_std_test.sv
